### design/spd_pkg.sv
// spd_pkg: shared constants and widths for the dense-graph shortest path block
// used by spd_wmat and shortest_path_dense_graph; no dependencies
`default_nettype none

package spd_pkg;

	// graph size and derived widths
	localparam int MAX_VERTICES = 16;
	localparam int VW           = $clog2(MAX_VERTICES);      // vertex index
	localparam int CW           = $clog2(MAX_VERTICES + 1);  // vertex count
	localparam int AW           = 2 * VW;                    // matrix address
	localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;

	// payload widths
	localparam int WW = 10;   // edge weight
	localparam int DW = 14;   // distance
	localparam int RW = 5;    // config write data, widest register

	localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};

	// config register indexes and reset values
	localparam logic [0:0] REG_VERTEX_COUNT  = 1'b0;
	localparam logic [0:0] REG_SOURCE_VERTEX = 1'b1;
	localparam logic [RW-1:0] VCOUNT_RST     = RW'(16);

endpackage

`default_nettype wire

### design/spd_wmat.sv
// spd_wmat: adjacency matrix store, one write and one registered read port
// entries never written since reset read as zero via per-entry valid bits; uses spd_pkg
`default_nettype none

module spd_wmat (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [spd_pkg::AW-1:0] wr_addr,
	input  logic [spd_pkg::WW-1:0] wr_data,
	input  logic                   rd_en,
	input  logic [spd_pkg::AW-1:0] rd_addr,
	output logic [spd_pkg::WW-1:0] rd_data
);

	logic [spd_pkg::WW-1:0]    mem_q [spd_pkg::DEPTH];
	logic [spd_pkg::DEPTH-1:0] vld_q;
	logic [spd_pkg::WW-1:0]    rd_s1;
	logic                      rd_vld_s1;

	// weight storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= mem_q[rd_addr];
		end
	end

	// per-entry written flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// unwritten entry means no edge
	assign rd_data = rd_vld_s1 ? rd_s1 : '0;

endmodule

`default_nettype wire

### design/shortest_path_dense_graph.sv
// shortest_path_dense_graph: single-source shortest paths over a stored adjacency matrix
// uses spd_pkg and spd_wmat; edge write words are taken one a cycle while not busy and
// may come back to back; a word with last set runs n-1 rounds (n = vertex count in use):
// a pick scan, plus a relax scan if the picked vertex is reached, then n strobed result
// words, one a cycle, that cannot be stalled; busy through the last result word; reset
// clears matrix, masks, control, config to n=16, source 0
`default_nettype none

module shortest_path_dense_graph (
	input  logic                   clk,
	input  logic                   arst_n,
	// edge write words
	input  logic                   start,
	output logic                   busy,
	input  logic [spd_pkg::VW-1:0] from_vertex,
	input  logic [spd_pkg::VW-1:0] to_vertex,
	input  logic [spd_pkg::WW-1:0] edge_weight,
	input  logic                   last,
	// config write port
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_addr,
	input  logic [spd_pkg::RW-1:0] cfg_wdata,
	// result words
	output logic                   res_valid,
	output logic [spd_pkg::VW-1:0] vertex,
	output logic [spd_pkg::DW-1:0] distance,
	output logic                   reachable,
	output logic                   final_res
);

	typedef enum logic [1:0] {ST_IDLE, ST_PICK, ST_RELAX, ST_OUT} state_t;

	state_t                           state_q;
	logic [spd_pkg::RW-1:0]           vc_q;
	logic [spd_pkg::VW-1:0]           src_q;
	logic [spd_pkg::CW-1:0]           n_q;
	logic [spd_pkg::CW-1:0]           cnt_q;
	logic [spd_pkg::CW-1:0]           rnd_q;
	logic [spd_pkg::MAX_VERTICES-1:0] visited_q;
	logic [spd_pkg::MAX_VERTICES-1:0] reached_q;
	logic                             have_q;
	logic [spd_pkg::VW-1:0]           best_q;
	logic [spd_pkg::DW-1:0]           bd_q;
	logic [spd_pkg::VW-1:0]           u_q;
	logic                             act_s1;
	logic [spd_pkg::VW-1:0]           v_s1;
	logic [spd_pkg::DW-1:0]           dist_rd_s1;

	logic [spd_pkg::DW-1:0] dist_mem_q [spd_pkg::MAX_VERTICES];

	logic                   accept;
	logic                   run;
	logic [spd_pkg::CW-1:0] n_act;
	logic                   src_ok;
	logic                   scan;
	logic                   rd_en;
	logic                   scan_end;
	logic                   rnd_last;
	logic [spd_pkg::VW-1:0] cnt_idx;

	logic                   pk_have;
	logic [spd_pkg::VW-1:0] pk_best;
	logic [spd_pkg::DW-1:0] pk_bd;

	logic [spd_pkg::WW-1:0] w_s1;
	logic [spd_pkg::DW:0]   rl_sum;
	logic [spd_pkg::DW-1:0] rl_sat;
	logic                   rl_upd;

	logic                   dist_we;
	logic [spd_pkg::VW-1:0] dist_wa;
	logic [spd_pkg::DW-1:0] dist_wd;

	// handshake and run setup
	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign run     = accept && last;
	assign cnt_idx = cnt_q[spd_pkg::VW-1:0];

	// clamp vertex count to the supported range
	always_comb begin
		if (vc_q < spd_pkg::RW'(2)) begin
			n_act = spd_pkg::CW'(2);
		end else if (vc_q > spd_pkg::RW'(spd_pkg::MAX_VERTICES)) begin
			n_act = spd_pkg::CW'(spd_pkg::MAX_VERTICES);
		end else begin
			n_act = spd_pkg::CW'(vc_q);
		end
	end

	assign src_ok   = ({1'b0, src_q} < n_act);
	assign scan     = (state_q == ST_PICK) || (state_q == ST_RELAX) || (state_q == ST_OUT);
	assign rd_en    = scan && (cnt_q != n_q);
	assign scan_end = (cnt_q == n_q);
	assign rnd_last = (rnd_q == n_q - spd_pkg::CW'(2));

	// adjacency matrix
	spd_wmat u_wmat (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_addr ({from_vertex, to_vertex}),
		.wr_data (edge_weight),
		.rd_en   (rd_en && (state_q == ST_RELAX)),
		.rd_addr ({u_q, cnt_idx}),
		.rd_data (w_s1)
	);

	// pick step: least unvisited reached distance, ties to higher index, else last unvisited
	always_comb begin
		pk_have = have_q;
		pk_best = best_q;
		pk_bd   = bd_q;
		if (act_s1 && !visited_q[v_s1]) begin
			if (reached_q[v_s1]) begin
				if (!have_q || (dist_rd_s1 <= bd_q)) begin
					pk_have = 1'b1;
					pk_best = v_s1;
					pk_bd   = dist_rd_s1;
				end
			end else if (!have_q) begin
				pk_best = v_s1;
			end
		end
	end

	// relax step: saturating sum and improvement check
	assign rl_sum = {1'b0, bd_q} + (spd_pkg::DW + 1)'(w_s1);
	assign rl_sat = (rl_sum > (spd_pkg::DW + 1)'(spd_pkg::DIST_MAX)) ?
		spd_pkg::DIST_MAX : rl_sum[spd_pkg::DW-1:0];
	assign rl_upd = (state_q == ST_RELAX) && act_s1 && !visited_q[v_s1] &&
		(w_s1 != '0) && (!reached_q[v_s1] || (rl_sat < dist_rd_s1));

	// distance memory write port: source seed at run start, else relax updates
	always_comb begin
		if (run) begin
			dist_we = src_ok;
			dist_wa = src_q;
			dist_wd = '0;
		end else begin
			dist_we = rl_upd;
			dist_wa = v_s1;
			dist_wd = rl_sat;
		end
	end

	// distance memory
	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem_q[dist_wa] <= dist_wd;
		end
		if (rd_en) begin
			dist_rd_s1 <= dist_mem_q[cnt_idx];
		end
	end

	// sequencer and masks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vc_q      <= spd_pkg::VCOUNT_RST;
			src_q     <= '0;
			n_q       <= spd_pkg::CW'(spd_pkg::MAX_VERTICES);
			cnt_q     <= '0;
			rnd_q     <= '0;
			visited_q <= '0;
			reached_q <= '0;
			have_q    <= 1'b0;
			best_q    <= '0;
			bd_q      <= '0;
			u_q       <= '0;
			act_s1    <= 1'b0;
			v_s1      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					spd_pkg::REG_VERTEX_COUNT:  vc_q  <= cfg_wdata;
					spd_pkg::REG_SOURCE_VERTEX: src_q <= cfg_wdata[spd_pkg::VW-1:0];
				endcase
			end
			act_s1 <= rd_en;
			v_s1   <= cnt_idx;
			unique case (state_q)
				ST_IDLE: begin
					if (run) begin
						n_q       <= n_act;
						visited_q <= '0;
						reached_q <= src_ok ?
							(spd_pkg::MAX_VERTICES'(1) << src_q) : '0;
						rnd_q   <= '0;
						cnt_q   <= '0;
						have_q  <= 1'b0;
						best_q  <= '0;
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					bd_q <= pk_bd;
					if (scan_end) begin
						cnt_q              <= '0;
						have_q             <= 1'b0;
						best_q             <= '0;
						visited_q[pk_best] <= 1'b1;
						u_q                <= pk_best;
						if (reached_q[pk_best]) begin
							state_q <= ST_RELAX;
						end else if (rnd_last) begin
							state_q <= ST_OUT;
						end else begin
							rnd_q <= rnd_q + spd_pkg::CW'(1);
						end
					end else begin
						have_q <= pk_have;
						best_q <= pk_best;
						cnt_q  <= cnt_q + spd_pkg::CW'(1);
					end
				end
				ST_RELAX: begin
					if (rl_upd) begin
						reached_q[v_s1] <= 1'b1;
					end
					if (scan_end) begin
						cnt_q  <= '0;
						have_q <= 1'b0;
						best_q <= '0;
						if (rnd_last) begin
							state_q <= ST_OUT;
						end else begin
							rnd_q   <= rnd_q + spd_pkg::CW'(1);
							state_q <= ST_PICK;
						end
					end else begin
						cnt_q <= cnt_q + spd_pkg::CW'(1);
					end
				end
				ST_OUT: begin
					if (scan_end) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + spd_pkg::CW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result word from the read stage
	assign res_valid = (state_q == ST_OUT) && act_s1;
	assign vertex    = v_s1;
	assign reachable = reached_q[v_s1];
	assign distance  = reached_q[v_s1] ? dist_rd_s1 : '0;
	assign final_res = ({1'b0, v_s1} == n_q - spd_pkg::CW'(1));

	// no result word outside a run
	assert property (@(posedge clk) disable iff (!arst_n) !busy |-> !res_valid)
		else $error("result strobe while idle");

	// the final word ends the run
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && final_res) |=> !busy)
		else $error("run continues after final word");

	// results come out in vertex order without gaps
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !final_res) |=> (res_valid && (vertex == $past(vertex) + 4'd1)))
		else $error("result words out of order");

	// relax write never hits the entry being read in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RELAX) && act_s1 && (cnt_q != n_q)) |-> (v_s1 != cnt_idx))
		else $error("distance memory read/write collision");

	// visited vertices stay visited during a run
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> ((visited_q & $past(visited_q)) == $past(visited_q)))
		else $error("visited bit lost during run");

endmodule

`default_nettype wire
